// ===== rtl/core/depth_surface_normals_defines.svh =====
// assertion macros shared by the depth surface normal design
`ifndef DEPTH_SURFACE_NORMALS_DEFINES_SVH
`define DEPTH_SURFACE_NORMALS_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define DSN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsn assertion failed");

// next-cycle implication, checked on clk outside reset
`define DSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsn assertion failed");

`endif

// ===== rtl/core/dsn_pkg.sv =====
// types and constants of the depth surface normal block
`default_nettype none
package dsn_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DEPTH_W    = 16;

  // cross product magnitudes stay below 2^50
  localparam int MAG_W  = 50;
  localparam int NRM_W  = 30;
  localparam int SQ_W   = 62;
  localparam int RT_W   = 31;
  localparam int Q_W    = 15;
  localparam int DVS_W  = RT_W + Q_W - 1;
  localparam int REM_W  = DVS_W + 1;

  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [MAG_W-1:0] NORM_HI   = MAG_W'(1) << 30;
  localparam logic [MAG_W-1:0] NORM_LO   = MAG_W'(1) << 29;
  localparam logic [MAG_W-1:0] COARSE_HI = MAG_W'(1) << 38;
  localparam logic [MAG_W-1:0] COARSE_LO = MAG_W'(1) << 21;

  localparam logic [2:0] MUL_LAST  = 3'd6;
  localparam logic [3:0] MOD_LAST  = 4'(ROW_W - 1);
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [3:0] DIV_LAST  = 4'(Q_W - 1);

  localparam int ADDR_W = 5;

  // register reset values
  localparam logic [15:0] FOCAL_X_RST    = 16'd9600;
  localparam logic [15:0] FOCAL_Y_RST    = 16'd9600;
  localparam logic [15:0] CENTER_X_RST   = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST   = 16'd3840;
  localparam logic [4:0]  GRID_STEP_RST  = 5'd2;
  localparam logic [11:0] LINE_WIDTH_RST = 12'd640;

  typedef enum logic [2:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_GRID_STEP  = 3'd4,
    REG_LINE_WIDTH = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MOD,
    S_MUL,
    S_MAG,
    S_MAX,
    S_NORM,
    S_SQ,
    S_SQRT,
    S_DIVI,
    S_DIV,
    S_RES
  } state_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic               normal_valid;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/dsn_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none
module dsn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/depth_surface_normals.sv =====
// depth image surface normal unit: line store, cross product and normalization
// a pixel in row 0 or column 0 gives no normal; one with an invalid normal skips the remaining steps;
// a full normal runs through the 32-step square root
// and the 15-step divider that share one sequencer, plus an 11-step grid remainder
// the next pixel is taken once the result is in the output register
// synchronous reset restores register defaults and clears counters; the line store
// is not cleared and holds unknown data until each column has been written
`default_nettype none
`include "depth_surface_normals_defines.svh"
module depth_surface_normals (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire dsn_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dsn_pkg::out_item_t               out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dsn_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  // configuration registers
  logic [15:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [4:0]  grid_step_r;
  logic [11:0] line_width_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  // control state
  dsn_pkg::state_t state_r, state_nxt;
  logic [dsn_pkg::COL_W-1:0]   col_cnt_r;
  logic [dsn_pkg::ROW_W-1:0]   row_cnt_r;
  logic [dsn_pkg::DEPTH_W-1:0] left_r, upleft_r;
  logic                        out_valid_r;
  dsn_pkg::out_item_t          out_data_r;

  // item registers
  logic [dsn_pkg::DEPTH_W-1:0] depth_r, z_r, zr_r, zd_r;
  logic [dsn_pkg::COL_W-1:0]   col_r, pc_r, pc_sh_r;
  logic [dsn_pkg::ROW_W-1:0]   row_r, pr_r, pr_sh_r;
  logic [5:0]                  mrow_r, mcol_r;
  logic [3:0]                  cnt4_r;
  logic [2:0]                  mul_idx_r;
  logic [1:0]                  sq_idx_r;
  logic [4:0]                  sqrt_cnt_r;
  logic signed [dsn_pkg::MUL_B_W-1:0] p1_r, p2_r;
  logic signed [dsn_pkg::MAG_W:0]     nx_r, ny_r, nz_r;
  logic [2:0]                  neg_r;
  logic [dsn_pkg::MAG_W-1:0]   m_r [3];
  logic [dsn_pkg::MAG_W-1:0]   big_r;
  logic [dsn_pkg::SQ_W-1:0]    s_r, v_r;
  logic [dsn_pkg::SQ_W:0]      res_r, bit_r;
  logic [dsn_pkg::DVS_W-1:0]   dvs_r;
  logic [dsn_pkg::REM_W-1:0]   rem_r [3];
  logic [dsn_pkg::Q_W-1:0]     q_r [3];
  logic                        ok_r;

  // combinational helpers
  logic                        accept, ram_we, out_load, fail;
  logic [dsn_pkg::COL_W-1:0]   col_use;
  logic [dsn_pkg::ROW_W-1:0]   row_use;
  logic [dsn_pkg::DEPTH_W-1:0] ram_rdata;
  logic [11:0]                 width_eff, col_inc;
  logic [4:0]                  step_eff;
  logic [5:0]                  mrow_sh, mcol_sh;
  logic                        has_res, zero_depth, off_grid;
  logic signed [16:0]          dr, dd, a_coef, b_coef;
  logic signed [dsn_pkg::MUL_A_W-1:0] mul_a;
  logic signed [dsn_pkg::MUL_B_W-1:0] mul_b;
  logic signed [dsn_pkg::MUL_P_W-1:0] mul_p;
  logic [dsn_pkg::NRM_W-1:0]   msel;
  logic [dsn_pkg::MAG_W-1:0]   big_c;
  logic                        big_in_range;
  logic [dsn_pkg::SQ_W:0]      sq_try;
  logic [dsn_pkg::RT_W-1:0]    root;
  logic signed [15:0]          nrm [3];

  // apb register port
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      dsn_pkg::REG_FOCAL_X:    prdata = {16'd0, focal_x_r};
      dsn_pkg::REG_FOCAL_Y:    prdata = {16'd0, focal_y_r};
      dsn_pkg::REG_CENTER_X:   prdata = {16'd0, center_x_r};
      dsn_pkg::REG_CENTER_Y:   prdata = {16'd0, center_y_r};
      dsn_pkg::REG_GRID_STEP:  prdata = {27'd0, grid_step_r};
      dsn_pkg::REG_LINE_WIDTH: prdata = {20'd0, line_width_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r    <= dsn_pkg::FOCAL_X_RST;
      focal_y_r    <= dsn_pkg::FOCAL_Y_RST;
      center_x_r   <= dsn_pkg::CENTER_X_RST;
      center_y_r   <= dsn_pkg::CENTER_Y_RST;
      grid_step_r  <= dsn_pkg::GRID_STEP_RST;
      line_width_r <= dsn_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dsn_pkg::REG_FOCAL_X:    focal_x_r    <= pwdata[15:0];
        dsn_pkg::REG_FOCAL_Y:    focal_y_r    <= pwdata[15:0];
        dsn_pkg::REG_CENTER_X:   center_x_r   <= pwdata[15:0];
        dsn_pkg::REG_CENTER_Y:   center_y_r   <= pwdata[15:0];
        dsn_pkg::REG_GRID_STEP:  grid_step_r  <= pwdata[4:0];
        dsn_pkg::REG_LINE_WIDTH: line_width_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // effective width and grid step
  always_comb begin
    if (line_width_r < 12'd2) begin
      width_eff = 12'd2;
    end else if (line_width_r > 12'(dsn_pkg::MAX_WIDTH)) begin
      width_eff = 12'(dsn_pkg::MAX_WIDTH);
    end else begin
      width_eff = line_width_r;
    end
  end
  assign step_eff = (grid_step_r == 5'd0) ? 5'd1 : grid_step_r;

  // position of the incoming pixel, frame start clears it
  assign col_use = in_data.frame_start ? '0 : col_cnt_r;
  assign row_use = in_data.frame_start ? '0 : row_cnt_r;
  assign col_inc = {1'b0, col_r} + 12'd1;

  // line store of the prior row
  dsn_ram #(.WIDTH(dsn_pkg::DEPTH_W), .DEPTH(dsn_pkg::MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_r),
    .wdata (depth_r),
    .raddr (col_use),
    .rdata (ram_rdata)
  );

  // decisions taken in the read cycle and after the grid remainder
  assign has_res    = (row_r != '0) && (col_r != '0);
  assign zero_depth = (upleft_r == '0) || (ram_rdata == '0) || (left_r == '0);
  assign off_grid   = (mrow_r != 6'd0) || (mcol_r != 6'd0);
  assign mrow_sh    = {mrow_r[4:0], pr_sh_r[dsn_pkg::ROW_W-1]};
  assign mcol_sh    = {mcol_r[4:0], pc_sh_r[dsn_pkg::COL_W-1]};

  // back-projection terms
  assign dr     = $signed({1'b0, zr_r}) - $signed({1'b0, z_r});
  assign dd     = $signed({1'b0, zd_r}) - $signed({1'b0, z_r});
  assign a_coef = $signed({2'b00, pc_r, 4'b0000}) - $signed({1'b0, center_x_r});
  assign b_coef = $signed({2'b00, pr_r, 4'b0000}) - $signed({1'b0, center_y_r});

  // shared multiplier operand selection
  always_comb begin
    unique case (sq_idx_r)
      2'd0:    msel = m_r[0][dsn_pkg::NRM_W-1:0];
      2'd1:    msel = m_r[1][dsn_pkg::NRM_W-1:0];
      default: msel = m_r[2][dsn_pkg::NRM_W-1:0];
    endcase
    mul_a = '0;
    mul_b = '0;
    if (state_r == dsn_pkg::S_SQ) begin
      mul_a = $signed({1'b0, msel});
      mul_b = $signed({3'b000, msel});
    end else begin
      unique case (mul_idx_r)
        3'd0: begin
          mul_a = 31'(dr);
          mul_b = $signed({17'd0, zd_r});
        end
        3'd1: begin
          mul_a = 31'(dd);
          mul_b = $signed({17'd0, zr_r});
        end
        3'd2: begin
          mul_a = $signed({15'd0, focal_x_r});
          mul_b = p1_r;
        end
        3'd3: begin
          mul_a = $signed({15'd0, focal_y_r});
          mul_b = p2_r;
        end
        3'd4: begin
          mul_a = 31'(a_coef);
          mul_b = p1_r;
        end
        3'd5: begin
          mul_a = 31'(b_coef);
          mul_b = p2_r;
        end
        3'd6: begin
          mul_a = $signed({15'd0, zr_r});
          mul_b = $signed({13'd0, zd_r, 4'b0000});
        end
        default: ;
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // largest magnitude, trial value of the square root and the root itself
  always_comb begin
    big_c = m_r[0];
    if (m_r[1] > big_c) big_c = m_r[1];
    if (m_r[2] > big_c) big_c = m_r[2];
  end
  assign big_in_range = (big_r < dsn_pkg::NORM_HI) && (big_r >= dsn_pkg::NORM_LO);
  assign sq_try = res_r + bit_r;
  assign root   = res_r[dsn_pkg::RT_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsn_pkg::S_IDLE: if (in_valid) state_nxt = dsn_pkg::S_READ;
      dsn_pkg::S_READ: begin
        priority if (!has_res) state_nxt = dsn_pkg::S_IDLE;
        else if (zero_depth)   state_nxt = dsn_pkg::S_RES;
        else                   state_nxt = dsn_pkg::S_MOD;
      end
      dsn_pkg::S_MOD: begin
        if (cnt4_r == dsn_pkg::MOD_LAST) state_nxt = dsn_pkg::S_MUL;
      end
      dsn_pkg::S_MUL: begin
        priority if (mul_idx_r == 3'd0 && off_grid) state_nxt = dsn_pkg::S_RES;
        else if (mul_idx_r == dsn_pkg::MUL_LAST)    state_nxt = dsn_pkg::S_MAG;
        else                                        state_nxt = dsn_pkg::S_MUL;
      end
      dsn_pkg::S_MAG: state_nxt = dsn_pkg::S_MAX;
      dsn_pkg::S_MAX: state_nxt = (big_c == '0) ? dsn_pkg::S_RES : dsn_pkg::S_NORM;
      dsn_pkg::S_NORM: begin
        if (big_in_range) begin
          state_nxt = dsn_pkg::S_SQ;
        end
      end
      dsn_pkg::S_SQ:   if (sq_idx_r == 2'd2) state_nxt = dsn_pkg::S_SQRT;
      dsn_pkg::S_SQRT: if (sqrt_cnt_r == dsn_pkg::SQRT_LAST) state_nxt = dsn_pkg::S_DIVI;
      dsn_pkg::S_DIVI: state_nxt = dsn_pkg::S_DIV;
      dsn_pkg::S_DIV:  if (cnt4_r == dsn_pkg::DIV_LAST) state_nxt = dsn_pkg::S_RES;
      dsn_pkg::S_RES:  if (out_load) state_nxt = dsn_pkg::S_IDLE;
      default:         state_nxt = dsn_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    out_load = 1'b0;
    fail     = 1'b0;
    unique case (state_r)
      dsn_pkg::S_IDLE: in_stall = 1'b0;
      dsn_pkg::S_READ: begin
        ram_we = 1'b1;
        fail   = has_res && zero_depth;
      end
      dsn_pkg::S_MUL:  fail = (mul_idx_r == 3'd0) && off_grid;
      dsn_pkg::S_MAX:  fail = (big_c == '0);
      dsn_pkg::S_RES:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end
  assign accept = in_valid && !in_stall;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsn_pkg::S_IDLE;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      left_r      <= '0;
      upleft_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == dsn_pkg::S_READ) begin
        upleft_r <= ram_rdata;
        left_r   <= depth_r;
        if (col_inc >= width_eff) begin
          col_cnt_r <= '0;
          row_cnt_r <= (row_r == dsn_pkg::ROW_W'(dsn_pkg::MAX_HEIGHT - 1)) ? '0 : row_r + 1'b1;
        end else begin
          col_cnt_r <= col_inc[dsn_pkg::COL_W-1:0];
          row_cnt_r <= row_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      depth_r <= in_data.depth;
      col_r   <= col_use;
      row_r   <= row_use;
    end
    if (fail) begin
      ok_r <= 1'b0;
      for (int i = 0; i < 3; i++) q_r[i] <= '0;
    end
    unique case (state_r)
      dsn_pkg::S_READ: begin
        z_r     <= upleft_r;
        zr_r    <= ram_rdata;
        zd_r    <= left_r;
        pr_r    <= row_r - 1'b1;
        pc_r    <= col_r - 1'b1;
        pr_sh_r <= row_r - 1'b1;
        pc_sh_r <= col_r - 1'b1;
        mrow_r  <= '0;
        mcol_r  <= '0;
        cnt4_r  <= '0;
        mul_idx_r <= '0;
      end
      dsn_pkg::S_MOD: begin
        // restoring remainder, one bit of row and column a cycle
        mrow_r  <= (mrow_sh >= {1'b0, step_eff}) ? mrow_sh - {1'b0, step_eff} : mrow_sh;
        mcol_r  <= (mcol_sh >= {1'b0, step_eff}) ? mcol_sh - {1'b0, step_eff} : mcol_sh;
        pr_sh_r <= pr_sh_r << 1;
        pc_sh_r <= pc_sh_r << 1;
        cnt4_r  <= cnt4_r + 1'b1;
      end
      dsn_pkg::S_MUL: begin
        mul_idx_r <= mul_idx_r + 1'b1;
        unique case (mul_idx_r)
          3'd0: p1_r <= 33'(mul_p);
          3'd1: p2_r <= 33'(mul_p);
          3'd2: nx_r <= -(51'(mul_p));
          3'd3: ny_r <= -(51'(mul_p));
          3'd4: nz_r <= 51'(mul_p);
          default: nz_r <= nz_r + 51'(mul_p);
        endcase
      end
      dsn_pkg::S_MAG: begin
        neg_r  <= {nz_r[dsn_pkg::MAG_W], ny_r[dsn_pkg::MAG_W], nx_r[dsn_pkg::MAG_W]};
        m_r[0] <= nx_r[dsn_pkg::MAG_W] ? 50'(-nx_r) : 50'(nx_r);
        m_r[1] <= ny_r[dsn_pkg::MAG_W] ? 50'(-ny_r) : 50'(ny_r);
        m_r[2] <= nz_r[dsn_pkg::MAG_W] ? 50'(-nz_r) : 50'(nz_r);
      end
      dsn_pkg::S_MAX: big_r <= big_c;
      dsn_pkg::S_NORM: begin
        // common shift: eight bits at a time while far off, then single bits
        priority if (big_r >= dsn_pkg::COARSE_HI) begin
          big_r <= big_r >> 8;
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 8;
        end else if (big_r >= dsn_pkg::NORM_HI) begin
          big_r <= big_r >> 1;
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end else if (big_r < dsn_pkg::COARSE_LO) begin
          big_r <= big_r << 8;
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 8;
        end else if (big_r < dsn_pkg::NORM_LO) begin
          big_r <= big_r << 1;
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
        end else begin
          s_r      <= '0;
          sq_idx_r <= '0;
        end
      end
      dsn_pkg::S_SQ: begin
        sq_idx_r <= sq_idx_r + 1'b1;
        s_r      <= s_r + 62'(mul_p);
        v_r      <= s_r + 62'(mul_p);
        res_r    <= '0;
        bit_r    <= 63'(1) << 62;
        sqrt_cnt_r <= '0;
      end
      dsn_pkg::S_SQRT: begin
        // one result bit per cycle
        if ({1'b0, v_r} >= sq_try) begin
          v_r   <= v_r - sq_try[dsn_pkg::SQ_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r      <= bit_r >> 2;
        sqrt_cnt_r <= sqrt_cnt_r + 1'b1;
      end
      dsn_pkg::S_DIVI: begin
        dvs_r  <= {root, 14'd0};
        cnt4_r <= '0;
        for (int i = 0; i < 3; i++) begin
          rem_r[i] <= {2'b00, m_r[i][dsn_pkg::NRM_W-1:0], 14'd0} + 46'(root >> 1);
          q_r[i]   <= '0;
        end
      end
      dsn_pkg::S_DIV: begin
        // three restoring dividers sharing the shifted root
        for (int i = 0; i < 3; i++) begin
          if (rem_r[i] >= {1'b0, dvs_r}) begin
            rem_r[i] <= rem_r[i] - {1'b0, dvs_r};
            q_r[i]   <= {q_r[i][dsn_pkg::Q_W-2:0], 1'b1};
          end else begin
            q_r[i]   <= {q_r[i][dsn_pkg::Q_W-2:0], 1'b0};
          end
        end
        dvs_r  <= dvs_r >> 1;
        cnt4_r <= cnt4_r + 1'b1;
        ok_r   <= 1'b1;
      end
      default: ;
    endcase
  end

  // signed q1.14 components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = neg_r[i] ? -$signed({1'b0, q_r[i]}) : $signed({1'b0, q_r[i]});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.normal_x     <= nrm[0];
      out_data_r.normal_y     <= nrm[1];
      out_data_r.normal_z     <= nrm[2];
      out_data_r.out_row      <= pr_r;
      out_data_r.out_col      <= pc_r;
      out_data_r.normal_valid <= ok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `DSN_ASSERT_NEXT(a_accept_reads, accept, state_r == dsn_pkg::S_READ)
  `DSN_ASSERT_NOW(a_norm_range, state_r == dsn_pkg::S_SQ, big_in_range)
  `DSN_ASSERT_NOW(a_root_floor, state_r == dsn_pkg::S_DIV, root >= dsn_pkg::RT_W'(1) << 29)
  `DSN_ASSERT_NOW(a_store_write, ram_we, state_r == dsn_pkg::S_READ && !in_stall == 1'b0)

endmodule
`default_nettype wire

// ===== tb/dsn_checker.sv =====
// checker for the depth surface normal block: watches both channels, predicts normals and compares
`default_nettype none
module dsn_checker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire dsn_pkg::in_item_t    in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire dsn_pkg::out_item_t   out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic                 pready,
  input  wire logic [dsn_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output int                        fail_count,
  output int                        normals_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dsn_pkg::*;

  // camera and stream settings as seen by the block
  logic [15:0] fx, fy, cx, cy;
  logic [4:0]  step_reg;
  logic [11:0] width_reg;

  // stream state
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] left_z, upleft_z;
  int unsigned col_pos, row_pos;

  out_item_t normal_q[$];

  assign normals_pending = normal_q.size();

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // scale the cross product to a Q1.14 unit vector; returns 0 for a zero vector
  function automatic bit unit_normal(input longint n [3], output logic [15:0] q [3]);
    logic [63:0] m [3];
    logic [63:0] big, s, root, v;
    for (int i = 0; i < 3; i++) m[i] = n[i] < 0 ? -n[i] : n[i];
    big = m[0];
    if (m[1] > big) big = m[1];
    if (m[2] > big) big = m[2];
    for (int i = 0; i < 3; i++) q[i] = 0;
    if (big == 0) return 0;
    while (big >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      big >>= 1;
    end
    while (big < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      big <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    root = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      v = (m[i] * 16384 + root / 2) / root;
      if (n[i] < 0) v = -v;
      q[i] = v[15:0];
    end
    return 1;
  endfunction

  // advance the stream by one pixel and queue the normal it completes
  task automatic predict_pixel(input in_item_t px);
    int unsigned w, stp, r, c, pr, pc;
    logic [15:0] above, z, zr, zd;
    longint a, b, dr, dd;
    longint n [3];
    logic [15:0] q [3];
    bit ok;
    out_item_t res;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    stp = step_reg == 0 ? 1 : step_reg;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
    above = line_mem[c];
    if (r >= 1 && c >= 1) begin
      pr = r - 1;
      pc = c - 1;
      z = upleft_z;
      zr = above;
      zd = left_z;
      ok = 0;
      for (int i = 0; i < 3; i++) q[i] = 0;
      if (pr % stp == 0 && pc % stp == 0 && z != 0 && zr != 0 && zd != 0) begin
        a = longint'(pc) * 16 - longint'(cx);
        b = longint'(pr) * 16 - longint'(cy);
        dr = longint'(zr) - longint'(z);
        dd = longint'(zd) - longint'(z);
        n[0] = -(longint'(fx) * dr * longint'(zd));
        n[1] = -(longint'(fy) * dd * longint'(zr));
        n[2] = a * dr * longint'(zd) + b * dd * longint'(zr) + 16 * longint'(zr) * longint'(zd);
        ok = unit_normal(n, q);
      end
      res.normal_x = q[0];
      res.normal_y = q[1];
      res.normal_z = q[2];
      res.out_row = pr[ROW_W-1:0];
      res.out_col = pc[COL_W-1:0];
      res.normal_valid = ok;
      normal_q.push_back(res);
    end
    upleft_z = above;
    line_mem[c] = px.depth;
    left_z = px.depth;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= MAX_HEIGHT) row_pos = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      fx <= FOCAL_X_RST;
      fy <= FOCAL_Y_RST;
      cx <= CENTER_X_RST;
      cy <= CENTER_Y_RST;
      step_reg <= GRID_STEP_RST;
      width_reg <= LINE_WIDTH_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_FOCAL_X:    fx <= pwdata[15:0];
        REG_FOCAL_Y:    fy <= pwdata[15:0];
        REG_CENTER_X:   cx <= pwdata[15:0];
        REG_CENTER_Y:   cy <= pwdata[15:0];
        REG_GRID_STEP:  step_reg <= pwdata[4:0];
        REG_LINE_WIDTH: width_reg <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // requests in, normals out
  initial fail_count = 0;
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      left_z = 0;
      upleft_z = 0;
      col_pos = 0;
      row_pos = 0;
      normal_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (normal_q.size() == 0) begin
          // normal arrived with none expected
          report_mismatch("unexpected normal", 1, 0);
        end else begin
          want = normal_q.pop_front();
          if (out_data.normal_x !== want.normal_x)
            report_mismatch("normal_x", out_data.normal_x, want.normal_x);
          if (out_data.normal_y !== want.normal_y)
            report_mismatch("normal_y", out_data.normal_y, want.normal_y);
          if (out_data.normal_z !== want.normal_z)
            report_mismatch("normal_z", out_data.normal_z, want.normal_z);
          if (out_data.out_row !== want.out_row)
            report_mismatch("out_row", out_data.out_row, want.out_row);
          if (out_data.out_col !== want.out_col)
            report_mismatch("out_col", out_data.out_col, want.out_col);
          if (out_data.normal_valid !== want.normal_valid)
            report_mismatch("normal_valid", out_data.normal_valid, want.normal_valid);
        end
      end
      if (in_valid && !in_stall) predict_pixel(in_data);
    end
  end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// top of the depth surface normal testbench: clock, reset, stimulus and verdict
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsn_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  in_item_t in_data;
  out_item_t out_data;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, normals_pending;

  int send_idle_pct, recv_idle_pct;
  bit hold_recv;
  int hold_cycles;
  int pixels_sent;

  depth_surface_normals DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dsn_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .normals_pending(normals_pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("depth_surface_normals test failed");
    $finish;
  end

  // receiver stall, with an optional long hold-off
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_recv && hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // offer one pixel and wait for its acceptance; valid drops only while idling
  task automatic send_pixel(input logic [15:0] z, input bit fs);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{depth: z, frame_start: fs};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    pixels_sent++;
  endtask

  // stop offering, wait until all normals have come, then for the block to settle
  task automatic drain();
    in_valid <= 0;
    while (normals_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_depth(input int zero_pct);
    if ($urandom_range(99) < zero_pct) return 16'd0;
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(1, 8));
      default: return 16'($urandom_range(900, 1200));
    endcase
  endfunction

  // one frame of random depths, rows of w pixels
  task automatic send_frame(input int w, input int rows, input int zero_pct);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < w; c++)
        send_pixel(rand_depth(zero_pct), r == 0 && c == 0);
  endtask

  initial begin
    int w;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_recv = 0;
    hold_cycles = 0;
    pixels_sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;

    // directed: narrow rows, step 1, extremes of depth
    cfg_write(REG_LINE_WIDTH, 4);
    cfg_write(REG_GRID_STEP, 0);
    send_pixel(16'hFFFF, 1); send_pixel(16'd1, 0); send_pixel(16'hFFFF, 0);
    send_pixel(16'd0, 0);
    send_pixel(16'd1, 0); send_pixel(16'hFFFF, 0); send_pixel(16'd1, 0);
    send_pixel(16'd500, 0);
    // flat patch gives a zero-free normal; equal depths
    send_pixel(16'd1000, 0); send_pixel(16'd1000, 0); send_pixel(16'd1000, 0);
    send_pixel(16'd1000, 0);
    send_pixel(16'd1000, 0); send_pixel(16'd0, 0); send_pixel(16'd1000, 0);
    send_pixel(16'd1000, 0);
    // frame start mid-row restarts at origin
    send_pixel(16'd700, 1); send_pixel(16'd800, 0); send_pixel(16'd900, 0);
    send_pixel(16'd700, 0);
    send_pixel(16'd710, 0); send_pixel(16'd0, 1);
    drain();

    // zero and maximal focal lengths and extreme centers
    cfg_write(REG_FOCAL_X, 0);
    cfg_write(REG_FOCAL_Y, 16'hFFFF);
    cfg_write(REG_CENTER_X, 16'hFFFF);
    cfg_write(REG_CENTER_Y, 0);
    cfg_write(REG_GRID_STEP, 31);
    send_frame(4, 3, 10);
    drain();
    cfg_write(REG_GRID_STEP, 1);
    send_frame(4, 3, 10);
    drain();

    // random frames in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 25 : ph == 1 ? 75 : 0;
      recv_idle_pct = ph == 0 ? 75 : ph == 1 ? 25 : 0;
      cfg_write(REG_FOCAL_X, ph == 2 ? 1 : $urandom_range(1, 65535));
      cfg_write(REG_FOCAL_Y, ph == 2 ? 16'hFFFF : $urandom_range(1, 65535));
      cfg_write(REG_CENTER_X, $urandom_range(65535));
      cfg_write(REG_CENTER_Y, $urandom_range(65535));
      cfg_write(REG_GRID_STEP, ph == 1 ? 16 : $urandom_range(1, 2));
      w = ph == 2 ? 2 : $urandom_range(3, 12);
      cfg_write(REG_LINE_WIDTH, w);
      if (ph == 1) begin
        // long receiver hold-off while pixels keep coming
        hold_cycles = 600;
        hold_recv = 1;
      end
      while (pixels_sent < 40 + (ph + 1) * 170)
        send_frame(w, $urandom_range(3, 8), 8);
      hold_recv = 0;
      drain();
    end

    // a zero line width acts as the narrowest row
    cfg_write(REG_GRID_STEP, 1);
    cfg_write(REG_LINE_WIDTH, 0);
    send_frame(2, 3, 0);
    drain();

    if (fail_count == 0)
      $display("depth_surface_normals test passed");
    else
      $display("depth_surface_normals test failed");
    $finish;
  end
endmodule
`default_nettype wire
